// ===== design/multi_reader_event_queue_core_assert.svh =====
// Assertion macros used by the event queue checker.
`ifndef MULTI_READER_EVENT_QUEUE_CORE_ASSERT_SVH
`define MULTI_READER_EVENT_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MRQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("event queue check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MRQ_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("event queue check failed");

`endif

// ===== design/mrq_pkg.sv =====
// Shared sizes, codes and control types of the multi-reader event queue.
package mrq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int MAX_READERS = 8;

	// Positions run modulo twice the depth so full and empty differ.
	localparam int PTR_SPAN = 2 * QUEUE_DEPTH;
	localparam int PTR_W    = $clog2(PTR_SPAN);
	localparam int SLOT_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int RIDX_W   = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
	localparam int RCNT_W   = $clog2(MAX_READERS + 1);

	localparam int OP_W      = 3;
	localparam int RID_W     = 3;
	localparam int KIND_W    = 16;
	localparam int PAYLOAD_W = 32;
	localparam int STATUS_W  = 3;
	localparam int ENTRY_W   = KIND_W + PAYLOAD_W;

	localparam int S_FIELDS_W = RID_W + 1 + KIND_W + PAYLOAD_W;
	localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_FIELDS_W = RID_W + KIND_W + PAYLOAD_W;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

	// Operation codes
	localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
	localparam logic [OP_W-1:0] OP_OPEN  = 3'd1;
	localparam logic [OP_W-1:0] OP_CLOSE = 3'd2;
	localparam logic [OP_W-1:0] OP_READ  = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

	// Result status codes
	localparam logic [STATUS_W-1:0] STS_OK          = 3'd0;
	localparam logic [STATUS_W-1:0] STS_DROPPED     = 3'd1;
	localparam logic [STATUS_W-1:0] STS_OVERFLOW    = 3'd2;
	localparam logic [STATUS_W-1:0] STS_NO_EVENT    = 3'd3;
	localparam logic [STATUS_W-1:0] STS_WOULD_BLOCK = 3'd4;
	localparam logic [STATUS_W-1:0] STS_INVALID     = 3'd5;
	localparam logic [STATUS_W-1:0] STS_NO_SLOT     = 3'd6;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_DISCARD,
		S_CHECK,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic scan_init;
		logic scan_step;
		logic discard;
		logic check;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic is_read;
		logic scan_end;
	} stat_t;

endpackage

// ===== design/mrq_ctrl.sv =====
// Sequencing state machine of the multi-reader event queue.
module mrq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  mrq_pkg::stat_t stat,
	output mrq_pkg::cmd_t  cmd
);
	import mrq_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || m_tready;

	// State register and output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = stat.is_read ? S_SCAN : S_DONE;
			end
			S_SCAN: begin
				if (stat.scan_end) state_d = S_DISCARD;
			end
			S_DISCARD: state_d = S_CHECK;
			S_CHECK:   state_d = S_DONE;
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Commands and handshake outputs
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		m_tvalid = out_valid_q;
		case (state_q)
			S_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			S_EXEC: begin
				cmd.exec      = 1'b1;
				cmd.scan_init = 1'b1;
			end
			S_SCAN:    cmd.scan_step = 1'b1;
			S_DISCARD: cmd.discard   = 1'b1;
			S_CHECK:   cmd.check     = 1'b1;
			S_DONE:    cmd.out_load  = out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== design/mrq_datapath.sv =====
// Queue store, reader table, discard scan and result registers.
module mrq_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mrq_pkg::cmd_t                   cmd,
	output mrq_pkg::stat_t                  stat,
	input  logic [mrq_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic [mrq_pkg::OP_W-1:0]        s_tuser,
	output logic [mrq_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic [mrq_pkg::STATUS_W-1:0]    m_tuser
);
	import mrq_pkg::*;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		logic [PTR_W:0] n;
		n = {1'b0, p} + 1'b1;
		return (n >= (PTR_W+1)'(PTR_SPAN)) ? '0 : n[PTR_W-1:0];
	endfunction

	function automatic logic [PTR_W-1:0] ptr_dist(input logic [PTR_W-1:0] from,
		input logic [PTR_W-1:0] to);
		logic [PTR_W:0] sum;
		if (to >= from) begin
			sum = {1'b0, to} - {1'b0, from};
		end else begin
			sum = {1'b0, to} + (PTR_W+1)'(PTR_SPAN) - {1'b0, from};
		end
		return sum[PTR_W-1:0];
	endfunction

	function automatic logic [SLOT_W-1:0] ptr_slot(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] s;
		s = (p >= PTR_W'(QUEUE_DEPTH)) ? p - PTR_W'(QUEUE_DEPTH) : p;
		return (s < PTR_W'(QUEUE_DEPTH)) ? s[SLOT_W-1:0] : '0;
	endfunction

	// Captured input beat
	logic [OP_W-1:0]      op_q;
	logic [RID_W-1:0]     rid_q;
	logic                 blk_q;
	logic [KIND_W-1:0]    kind_q;
	logic [PAYLOAD_W-1:0] payload_q;

	// Queue and reader state
	logic [PTR_W-1:0]       head_q, tail_q;
	logic [PTR_W-1:0]       reader_ptr_q [MAX_READERS];
	logic [MAX_READERS-1:0] open_q, blocks_q;
	logic [RCNT_W-1:0]      slots_q;

	// Discard scan
	logic [RCNT_W-1:0] scan_cnt_q;
	logic              any_q, zero_q;
	logic [PTR_W-1:0]  lowest_q;

	// Event store
	logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
	logic [ENTRY_W-1:0] rdata_q;

	// Result and output registers
	logic [STATUS_W-1:0]  res_status_q;
	logic [RID_W-1:0]     res_slot_q;
	logic                 hit_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [RID_W-1:0]     out_slot_q;
	logic [KIND_W-1:0]    out_kind_q;
	logic [PAYLOAD_W-1:0] out_payload_q;

	logic [PTR_W-1:0]  count, rd_ptr, rd_dist, scan_dist, low_clamp;
	logic [PTR_W:0]    head_sum;
	logic [RIDX_W-1:0] rid_idx, scan_idx, rp_idx, free_idx, open_idx;
	logic              rid_ok, rid_live, read_hit, free_found, can_new, open_ok;
	logic              push_ok, mem_we, mem_re;

	// Decode occupancy and reader lookups
	always_comb begin
		count     = ptr_dist(head_q, tail_q);
		rid_idx   = RIDX_W'(rid_q);
		scan_idx  = scan_cnt_q[RIDX_W-1:0];
		rp_idx    = cmd.check ? rid_idx : scan_idx;
		rd_ptr    = reader_ptr_q[rp_idx];
		rd_dist   = ptr_dist(head_q, rd_ptr);
		scan_dist = rd_dist;
		rid_ok    = {{RCNT_W{1'b0}}, rid_q} < {{RID_W{1'b0}}, slots_q};
		rid_live  = rid_ok && open_q[rid_idx];
		read_hit  = rid_live && (rd_dist < count);
		push_ok   = (slots_q != '0) && (count < PTR_W'(QUEUE_DEPTH));
		mem_we    = cmd.exec && (op_q == OP_PUSH) && push_ok;
		mem_re    = cmd.check && read_hit;
		low_clamp = (lowest_q > count) ? count : lowest_q;
		head_sum  = {1'b0, head_q} + {1'b0, low_clamp};
		if (head_sum >= (PTR_W+1)'(PTR_SPAN)) begin
			head_sum = head_sum - (PTR_W+1)'(PTR_SPAN);
		end
	end

	// Find the lowest closed slot among those allocated
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = MAX_READERS - 1; i >= 0; i--) begin
			if (!open_q[i] && (RCNT_W'(i) < slots_q)) begin
				free_found = 1'b1;
				free_idx   = RIDX_W'(i);
			end
		end
		can_new  = slots_q < RCNT_W'(MAX_READERS);
		open_ok  = free_found || can_new;
		open_idx = free_found ? free_idx : slots_q[RIDX_W-1:0];
	end

	assign stat.is_read  = (op_q == OP_READ);
	assign stat.scan_end = zero_q || (scan_cnt_q >= slots_q);

	// Capture the input beat
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= s_tuser;
			rid_q     <= s_tdata[RID_W-1:0];
			blk_q     <= s_tdata[RID_W];
			kind_q    <= s_tdata[RID_W+1 +: KIND_W];
			payload_q <= s_tdata[RID_W+1+KIND_W +: PAYLOAD_W];
		end
	end

	// Update queue pointers, reader table and scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			open_q     <= '0;
			blocks_q   <= '0;
			slots_q    <= '0;
			scan_cnt_q <= '0;
			any_q      <= 1'b0;
			zero_q     <= 1'b0;
			lowest_q   <= '0;
			for (int i = 0; i < MAX_READERS; i++) reader_ptr_q[i] <= '0;
		end else begin
			if (cmd.exec) begin
				case (op_q)
					OP_PUSH: begin
						if (push_ok) tail_q <= ptr_next(tail_q);
					end
					OP_OPEN: begin
						if (open_ok) begin
							open_q[open_idx]       <= 1'b1;
							reader_ptr_q[open_idx] <= head_q;
							if (!free_found) begin
								blocks_q[open_idx] <= blk_q;
								slots_q            <= slots_q + 1'b1;
							end
						end
					end
					OP_CLOSE: begin
						if (rid_ok) open_q[rid_idx] <= 1'b0;
					end
					OP_CLEAR: begin
						head_q   <= '0;
						tail_q   <= '0;
						open_q   <= '0;
						blocks_q <= '0;
						slots_q  <= '0;
						for (int i = 0; i < MAX_READERS; i++) reader_ptr_q[i] <= '0;
					end
					default: begin
					end
				endcase
			end
			// Walk the readers one per cycle for the lowest distance
			if (cmd.scan_init) begin
				scan_cnt_q <= '0;
				any_q      <= 1'b0;
				zero_q     <= 1'b0;
			end else if (cmd.scan_step && !stat.scan_end) begin
				if (open_q[scan_idx]) begin
					if (scan_dist == '0) begin
						zero_q <= 1'b1;
					end else begin
						if (!any_q || (scan_dist < lowest_q)) lowest_q <= scan_dist;
						any_q <= 1'b1;
					end
				end
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
			// Drop events every open reader has passed
			if (cmd.discard && any_q && !zero_q) begin
				head_q <= head_sum[PTR_W-1:0];
			end
			// Advance the reader past the event it takes
			if (cmd.check && read_hit) begin
				reader_ptr_q[rid_idx] <= ptr_next(rd_ptr);
			end
		end
	end

	// Event store write and registered read
	always_ff @(posedge clk) begin
		if (mem_we) mem[ptr_slot(tail_q)] <= {kind_q, payload_q};
		if (mem_re) rdata_q <= mem[ptr_slot(rd_ptr)];
	end

	// Form the result
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_slot_q   <= '0;
			hit_q        <= 1'b0;
			res_status_q <= STS_OK;
			case (op_q)
				OP_PUSH: begin
					if (slots_q == '0) begin
						res_status_q <= STS_DROPPED;
					end else if (!push_ok) begin
						res_status_q <= STS_OVERFLOW;
					end
				end
				OP_OPEN: begin
					if (open_ok) begin
						res_slot_q <= RID_W'(open_idx);
					end else begin
						res_status_q <= STS_NO_SLOT;
					end
				end
				OP_CLOSE: begin
					if (!rid_ok) res_status_q <= STS_INVALID;
				end
				default: begin
				end
			endcase
		end
		if (cmd.check) begin
			hit_q <= read_hit;
			if (!rid_live) begin
				res_status_q <= STS_INVALID;
			end else if (read_hit) begin
				res_status_q <= STS_OK;
			end else begin
				res_status_q <= blocks_q[rid_idx] ? STS_WOULD_BLOCK : STS_NO_EVENT;
			end
		end
	end

	// Load the output beat
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q  <= res_status_q;
			out_slot_q    <= res_slot_q;
			out_kind_q    <= hit_q ? rdata_q[ENTRY_W-1 -: KIND_W] : '0;
			out_payload_q <= hit_q ? rdata_q[PAYLOAD_W-1:0] : '0;
		end
	end

	assign m_tdata = M_TDATA_W'({out_payload_q, out_kind_q, out_slot_q});
	assign m_tuser = out_status_q;

endmodule

// ===== design/multi_reader_event_queue_core.sv =====
// Top level of the multi-reader broadcast event queue.
//
// One request beat in on the s_ channel gives exactly one result beat out
// on the m_ channel, in order. s_tuser carries the operation (push, open,
// close, read, clear); s_tdata carries reader slot, block flag and event.
// m_tuser carries the status; m_tdata the given slot and the read event.
// Requests are taken one at a time: s_tready is high only while idle.
// Push, open, close and clear execute and go straight to the result beat.
// A read first runs the discard scan: it visits one allocated reader
// slot per cycle to find the lowest read position, stops early at a
// reader that sits on the oldest event; then one step moves the head
// and one looks up the reader and reads the event store.
// The result waits in an output register; a new request is accepted while
// the receiver stalls, and its result is held until that register frees.
// Reset empties the queue and closes all readers; the event store itself
// is not cleared and needs no sweep.
module multi_reader_event_queue_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// reader_id[2:0], block_on_empty[3], event_kind[19:4], event_payload[51:20]
	input  logic [mrq_pkg::S_TDATA_W-1:0]    s_tdata,
	// op[2:0]
	input  logic [mrq_pkg::OP_W-1:0]         s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// slot_given[2:0], kind_out[18:3], payload_out[50:19]
	output logic [mrq_pkg::M_TDATA_W-1:0]    m_tdata,
	// status[2:0]
	output logic [mrq_pkg::STATUS_W-1:0]     m_tuser
);
	import mrq_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	mrq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mrq_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule

// ===== design/mrq_checker.sv =====
// Port-level checks of the event queue, bound to the top level.
`include "multi_reader_event_queue_core_assert.svh"

module mrq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [mrq_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [mrq_pkg::STATUS_W-1:0]  m_tuser
);
	import mrq_pkg::*;

	// Stalled result beat holds
	`MRQ_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// One request in flight: ready drops after each accepted beat
	`MRQ_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)

	// A new result appears only after the block has been busy
	`MRQ_ASSERT_IMP(a_result_after_work, $rose(m_tvalid), !$past(s_tready))

	// Failed operations carry no slot and no event
	`MRQ_ASSERT_IMP(a_fail_no_data, m_tvalid && (m_tuser != STS_OK), m_tdata == '0)

endmodule

bind multi_reader_event_queue_core mrq_checker u_mrq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== sim/multi_reader_event_queue_core_tb.sv =====
// Self-checking testbench for the multi-reader broadcast event queue core.
module multi_reader_event_queue_core_tb;
	import mrq_pkg::*;

	localparam int RANDOM_ITEMS  = 1050;
	localparam int DRAIN_EVERY   = 300;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 40;

	typedef enum int {
		TRAFFIC_FILL,
		TRAFFIC_MIX,
		TRAFFIC_DRAIN
	} traffic_mode_t;

	typedef struct {
		logic [STATUS_W-1:0]  status;
		logic [RID_W-1:0]     slot;
		logic [KIND_W-1:0]    kind;
		logic [PAYLOAD_W-1:0] payload;
	} reply_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [OP_W-1:0]      s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]  m_tuser;

	// Mirror of the queue contents and reader table
	logic [KIND_W-1:0]    kind_mem [QUEUE_DEPTH];
	logic [PAYLOAD_W-1:0] payload_mem [QUEUE_DEPTH];
	logic [PTR_W-1:0]     head_pos;
	logic [PTR_W-1:0]     tail_pos;
	logic [PTR_W-1:0]     rd_pos [MAX_READERS];
	logic                 rd_open [MAX_READERS];
	logic                 rd_blocks [MAX_READERS];
	logic [RCNT_W-1:0]    slots_used;

	reply_t replies_due [$];
	int     error_count;
	int     items_sent;
	int     cycle_count;
	bit     steady_flow;
	int     stall_left;

	multi_reader_event_queue_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Ring distance between two positions modulo twice the depth
	function automatic int ring_dist(int from, int to);
		return (to >= from) ? to - from : to + PTR_SPAN - from;
	endfunction

	function automatic logic [SLOT_W-1:0] store_index(int p);
		return SLOT_W'((p >= QUEUE_DEPTH) ? p - QUEUE_DEPTH : p);
	endfunction

	function automatic void forget_readers();
		head_pos   = '0;
		tail_pos   = '0;
		slots_used = '0;
		for (int i = 0; i < MAX_READERS; i++) begin
			rd_pos[i]    = '0;
			rd_open[i]   = 1'b0;
			rd_blocks[i] = 1'b0;
		end
	endfunction

	// Advance the head past events that every open reader has seen
	function automatic void retire_consumed();
		int count;
		int lowest;
		int d;
		bit any;
		count  = ring_dist(head_pos, tail_pos);
		lowest = 0;
		any    = 1'b0;
		for (int i = 0; i < slots_used && i < MAX_READERS; i++) begin
			if (rd_open[i]) begin
				d = ring_dist(head_pos, rd_pos[i]);
				if (d == 0)
					return;
				if (!any || d < lowest)
					lowest = d;
				any = 1'b1;
			end
		end
		if (!any)
			return;
		if (lowest > count)
			lowest = count;
		head_pos = PTR_W'((int'(head_pos) + lowest) % PTR_SPAN);
	endfunction

	// Apply one request to the mirror and return the reply it causes
	function automatic reply_t queue_reply(logic [OP_W-1:0] op, logic [RID_W-1:0] rid,
			logic blk, logic [KIND_W-1:0] kind, logic [PAYLOAD_W-1:0] payload);
		reply_t rp;
		bit found;
		logic [RIDX_W-1:0] idx;
		logic [SLOT_W-1:0] s;
		rp.status  = STS_OK;
		rp.slot    = '0;
		rp.kind    = '0;
		rp.payload = '0;
		found      = 1'b0;
		idx        = '0;
		case (op)
			OP_PUSH: begin
				if (slots_used == 0) begin
					rp.status = STS_DROPPED;
				end else if (ring_dist(head_pos, tail_pos) >= QUEUE_DEPTH) begin
					rp.status = STS_OVERFLOW;
				end else begin
					s = store_index(tail_pos);
					kind_mem[s]    = kind;
					payload_mem[s] = payload;
					tail_pos = PTR_W'((int'(tail_pos) + 1) % PTR_SPAN);
				end
			end
			OP_OPEN: begin
				for (int i = 0; i < slots_used; i++) begin
					if (!found && !rd_open[i]) begin
						found = 1'b1;
						idx   = RIDX_W'(i);
					end
				end
				// a new slot takes the block flag; a reused one keeps its own
				if (!found && slots_used < MAX_READERS) begin
					idx            = slots_used[RIDX_W-1:0];
					slots_used     = slots_used + 1'b1;
					rd_blocks[idx] = blk;
					found          = 1'b1;
				end
				if (found) begin
					rd_open[idx] = 1'b1;
					rd_pos[idx]  = head_pos;
					rp.slot      = RID_W'(idx);
				end else begin
					rp.status = STS_NO_SLOT;
				end
			end
			OP_CLOSE: begin
				if (rid < slots_used)
					rd_open[rid] = 1'b0;
				else
					rp.status = STS_INVALID;
			end
			OP_READ: begin
				retire_consumed();
				if (rid >= slots_used || !rd_open[rid]) begin
					rp.status = STS_INVALID;
				end else if (ring_dist(head_pos, rd_pos[rid]) < ring_dist(head_pos, tail_pos)) begin
					s = store_index(rd_pos[rid]);
					rp.kind    = kind_mem[s];
					rp.payload = payload_mem[s];
					rd_pos[rid] = PTR_W'((int'(rd_pos[rid]) + 1) % PTR_SPAN);
				end else begin
					rp.status = rd_blocks[rid] ? STS_WOULD_BLOCK : STS_NO_EVENT;
				end
			end
			OP_CLEAR: begin
				forget_readers();
			end
			default: begin
			end
		endcase
		return rp;
	endfunction

	// Mostly short idle gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		if (steady_flow)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Present one request beat, wait for the handshake, then record its reply
	task automatic send_request(input logic [OP_W-1:0] op, input logic [RID_W-1:0] rid,
			input logic blk, input logic [KIND_W-1:0] kind,
			input logic [PAYLOAD_W-1:0] payload);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= S_TDATA_W'({payload, kind, blk, rid});
		do @(posedge clk); while (!s_tready);
		replies_due.push_back(queue_reply(op, rid, blk, kind, payload));
		items_sent++;
	endtask

	// Hold the sender until every outstanding reply has come back
	task automatic wait_for_drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [RID_W-1:0] pick_reader();
		if (slots_used > 0 && $urandom_range(0, 99) < 85)
			return RID_W'($urandom_range(0, slots_used - 1));
		return RID_W'($urandom_range(0, 7));
	endfunction

	// One random request; the mode biases it toward filling or draining
	task automatic send_random(input traffic_mode_t mode);
		logic [OP_W-1:0] op;
		logic [RID_W-1:0] rid;
		int r;
		int push_lim;
		int read_lim;
		int open_lim;
		int close_lim;
		r   = $urandom_range(0, 99);
		rid = pick_reader();
		case (mode)
			TRAFFIC_FILL: begin
				push_lim = 70; read_lim = 85; open_lim = 92; close_lim = 96;
			end
			TRAFFIC_DRAIN: begin
				push_lim = 15; read_lim = 80; open_lim = 88; close_lim = 94;
			end
			default: begin
				push_lim = 35; read_lim = 70; open_lim = 80; close_lim = 90;
			end
		endcase
		if (r < push_lim) begin
			op = OP_PUSH;
		end else if (r < read_lim) begin
			op = OP_READ;
		end else if (r < open_lim) begin
			op = OP_OPEN;
		end else if (r < close_lim) begin
			op = OP_CLOSE;
		end else begin
			// noise: any code, any slot
			op  = OP_W'($urandom_range(0, 7));
			rid = RID_W'($urandom_range(0, 7));
		end
		send_request(op, rid, 1'($urandom_range(0, 1)), KIND_W'($urandom),
			PAYLOAD_W'($urandom));
	endtask

	// Push and access an empty table of readers
	task automatic test_no_readers();
		send_request(OP_PUSH, 3'd0, 1'b0, 16'hFFFF, 32'hFFFF_FFFF);
		send_request(OP_READ, 3'd0, 1'b0, '0, '0);
		send_request(OP_CLOSE, 3'd7, 1'b1, '0, '0);
		send_request(OP_READ, 3'd7, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
	endtask

	task automatic test_basic_events();
		send_request(OP_OPEN, 3'd0, 1'b1, '0, '0);
		send_request(OP_READ, 3'd0, 1'b0, '0, '0);
		send_request(OP_PUSH, 3'd0, 1'b0, 16'hFFFF, 32'hFFFF_FFFF);
		send_request(OP_PUSH, 3'd7, 1'b1, 16'h0000, 32'h0000_0000);
		send_request(OP_READ, 3'd0, 1'b0, '0, '0);
		send_request(OP_READ, 3'd0, 1'b0, '0, '0);
		send_request(OP_READ, 3'd0, 1'b0, '0, '0);
		send_request(OP_OPEN, 3'd0, 1'b0, '0, '0);
		send_request(OP_READ, 3'd1, 1'b0, '0, '0);
	endtask

	// Close twice, then reopen: the slot keeps its old block flag
	task automatic test_slot_reuse();
		send_request(OP_CLOSE, 3'd0, 1'b0, '0, '0);
		send_request(OP_CLOSE, 3'd0, 1'b0, '0, '0);
		send_request(OP_READ, 3'd0, 1'b0, '0, '0);
		send_request(OP_OPEN, 3'd5, 1'b0, '0, '0);
		send_request(OP_READ, 3'd0, 1'b0, '0, '0);
		send_request(OP_PUSH, 3'd0, 1'b0, 16'h5AA5, 32'hA55A_1234);
		send_request(OP_READ, 3'd1, 1'b0, '0, '0);
	endtask

	task automatic test_unknown_ops();
		send_request(OP_W'(5), 3'd7, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
		send_request(OP_W'(6), 3'd0, 1'b0, 16'h0000, 32'h0000_0000);
		send_request(OP_W'(7), 3'd7, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
	endtask

	task automatic test_clear();
		send_request(OP_CLEAR, 3'd0, 1'b0, '0, '0);
		send_request(OP_PUSH, 3'd0, 1'b0, 16'h1234, 32'h89AB_CDEF);
		send_request(OP_READ, 3'd0, 1'b0, '0, '0);
	endtask

	// Fill past the depth, free room by reading, then refill to full
	task automatic test_queue_full();
		send_request(OP_OPEN, 3'd0, 1'b0, '0, '0);
		repeat (QUEUE_DEPTH + 2)
			send_request(OP_PUSH, 3'd0, 1'b0, KIND_W'($urandom), PAYLOAD_W'($urandom));
		repeat (3)
			send_request(OP_READ, 3'd0, 1'b0, '0, '0);
		repeat (3)
			send_request(OP_PUSH, 3'd0, 1'b0, KIND_W'($urandom), PAYLOAD_W'($urandom));
		send_request(OP_CLOSE, 3'd0, 1'b0, '0, '0);
		send_request(OP_READ, 3'd0, 1'b0, '0, '0);
		send_request(OP_OPEN, 3'd0, 1'b1, '0, '0);
		send_request(OP_READ, 3'd0, 1'b0, '0, '0);
		send_request(OP_CLEAR, 3'd0, 1'b0, '0, '0);
	endtask

	// Use up every reader slot, then reuse one from the middle
	task automatic test_slot_exhaustion();
		for (int i = 0; i <= MAX_READERS; i++)
			send_request(OP_OPEN, 3'd0, 1'(i % 2), '0, '0);
		send_request(OP_PUSH, 3'd0, 1'b0, 16'hBEEF, 32'hDEAD_0001);
		send_request(OP_READ, 3'd7, 1'b0, '0, '0);
		send_request(OP_READ, 3'd7, 1'b0, '0, '0);
		send_request(OP_READ, 3'd6, 1'b0, '0, '0);
		send_request(OP_CLOSE, 3'd3, 1'b0, '0, '0);
		send_request(OP_OPEN, 3'd0, 1'b1, '0, '0);
		send_request(OP_READ, 3'd3, 1'b0, '0, '0);
		send_request(OP_READ, 3'd3, 1'b0, '0, '0);
		send_request(OP_CLEAR, 3'd0, 1'b0, '0, '0);
	endtask

	// Episodes of biased random traffic, with periodic full drains
	task automatic test_random_traffic();
		int start_count;
		int last_drain;
		int len;
		traffic_mode_t mode;
		start_count = items_sent;
		last_drain  = items_sent;
		while (items_sent - start_count < RANDOM_ITEMS) begin
			mode        = traffic_mode_t'($urandom_range(0, 2));
			len         = $urandom_range(10, 80);
			steady_flow = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) == 0)
				send_request(OP_CLEAR, RID_W'($urandom), 1'($urandom), KIND_W'($urandom),
					PAYLOAD_W'($urandom));
			// start most episodes with at least one reader
			if (slots_used == 0 || $urandom_range(0, 3) == 0)
				send_request(OP_OPEN, RID_W'($urandom), 1'($urandom), KIND_W'($urandom),
					PAYLOAD_W'($urandom));
			repeat (len)
				send_random(mode);
			if (items_sent - last_drain >= DRAIN_EVERY) begin
				wait_for_drain();
				last_drain = items_sent;
			end
		end
		steady_flow = 1'b0;
	endtask

	// Receiver side: random stalls on m_tready
	initial begin
		m_tready   = 1'b1;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (!steady_flow && $urandom_range(0, 99) < 30)
					stall_left = pick_gap();
			end
		end
	end

	// Compare each result beat with the oldest outstanding reply
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (replies_due.size() == 0) begin
				$error("result beat with no reply outstanding: status %0d", m_tuser);
				error_count++;
			end else begin
				want = replies_due.pop_front();
				if (m_tuser !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, m_tuser);
					error_count++;
				end
				if (m_tdata[2:0] !== want.slot) begin
					$error("slot_given: expected %0d, actual %0d", want.slot, m_tdata[2:0]);
					error_count++;
				end
				if (m_tdata[18:3] !== want.kind) begin
					$error("kind_out: expected %h, actual %h", want.kind, m_tdata[18:3]);
					error_count++;
				end
				if (m_tdata[50:19] !== want.payload) begin
					$error("payload_out: expected %h, actual %h", want.payload, m_tdata[50:19]);
					error_count++;
				end
			end
		end
	end

	// Watchdog on total run length
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = '0;
		error_count = 0;
		items_sent  = 0;
		steady_flow = 1'b0;
		forget_readers();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		test_no_readers();
		test_basic_events();
		test_slot_reuse();
		test_unknown_ops();
		test_clear();
		wait_for_drain();
		test_queue_full();
		test_slot_exhaustion();
		test_random_traffic();

		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
